@@ rtl/ufd_pkg.sv @@
// ----------------------------------------------------------------------------
// ufd_pkg: shared types and constants of the UART frame deframer
// Register indexes, reset values, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ufd_pkg;

  localparam int RING_DEPTH_DEF  = 64;
  localparam int MAX_PAYLOAD_DEF = 48;

  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 3;

  // head, type, command, two length bytes, checksum, end
  localparam int FRAME_OVERHEAD = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [BYTE_W-1:0] HEAD_RESET    = 8'hAA;
  localparam logic [BYTE_W-1:0] END_RESET     = 8'hDD;
  localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd250;

  localparam logic [BYTE_W-1:0] TYPE_ANSWER = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_INFORM = 8'h02;

  typedef enum logic [STATUS_W-1:0] {
    ST_ANSWER_OK    = 3'd0,
    ST_INFORM_OK    = 3'd1,
    ST_TOO_SHORT    = 3'd2,
    ST_CSUM_ERR     = 3'd3,
    ST_UNKNOWN_TYPE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HUNT_RD,
    S_HUNT_CHK,
    S_LEN_HI,
    S_LEN_LO,
    S_TICK,
    S_END_CHK,
    S_SUM,
    S_CSUM,
    S_PAYLOAD,
    S_FAIL,
    S_CONSUME
  } ctrl_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] head_value;
    logic [BYTE_W-1:0] end_value;
    logic [BYTE_W-1:0] timeout_ticks;
  } cfg_t;

endpackage

@@ rtl/ufd_if.sv @@
// ----------------------------------------------------------------------------
// ufd_if: valid/ready channels of the UART frame deframer
// Input item channel and result item channel.
// ----------------------------------------------------------------------------
interface ufd_in_if import ufd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface ufd_out_if import ufd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   frame_type;
  logic [BYTE_W-1:0]   command_code;
  logic [COUNT_W-1:0]  payload_count;
  logic [BYTE_W-1:0]   payload_value;
  logic [COUNT_W-1:0]  payload_position;
  logic                last;

  modport source (output valid, output status, output frame_type, output command_code,
                  output payload_count, output payload_value, output payload_position,
                  output last, input ready);
  modport sink   (input valid, input status, input frame_type, input command_code,
                  input payload_count, input payload_value, input payload_position,
                  input last, output ready);
endinterface

@@ rtl/ufd_ram.sv @@
// ----------------------------------------------------------------------------
// ufd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module ufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ufd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ufd_ctrl: ring pointers and frame sequencer
// Stores bytes, hunts for a head, checks length, end and sum, emits results.
// ----------------------------------------------------------------------------
module ufd_ctrl import ufd_pkg::*; #(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  ufd_in_if.sink                        in_ch,
  ufd_out_if.source                     out_ch,
  output logic                          ram_we,
  output logic [$clog2(RING_DEPTH)-1:0] ram_waddr,
  output logic [BYTE_W-1:0]             ram_wdata,
  output logic                          ram_re,
  output logic [$clog2(RING_DEPTH)-1:0] ram_raddr,
  input  logic [BYTE_W-1:0]             ram_rdata
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int XW = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);
  localparam int NW = $clog2(MAX_PAYLOAD + 1);
  localparam int SW = ((AW > XW) ? AW : XW) + 1;
  localparam int CW = (FW > XW) ? FW : XW;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [XW-1:0] o);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(o);
    if (s >= SW'(RING_DEPTH)) begin
      s = s - SW'(RING_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  ctrl_state_t       state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [BYTE_W-1:0] wc_r, wc_nxt;
  logic              tick_r, tick_nxt;
  logic              ov_r, ov_nxt;

  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [XW-1:0]     idx_r, idx_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] code_r, code_nxt;
  status_t           status_r, status_nxt;

  status_t            o_status_r, o_status_nxt;
  logic [BYTE_W-1:0]  o_type_r, o_type_nxt;
  logic [BYTE_W-1:0]  o_code_r, o_code_nxt;
  logic [COUNT_W-1:0] o_count_r, o_count_nxt;
  logic [BYTE_W-1:0]  o_value_r, o_value_nxt;
  logic [COUNT_W-1:0] o_pos_r, o_pos_nxt;
  logic               o_last_r, o_last_nxt;

  logic [XW-1:0] rd_off;
  logic [XW-1:0] lo_total;
  logic [XW-1:0] n_total;
  logic          slot_free;
  logic          pay_last;

  assign lo_total  = XW'(ram_rdata) + XW'(FRAME_OVERHEAD);
  assign n_total   = XW'(n_r) + XW'(FRAME_OVERHEAD);
  assign slot_free = !ov_r || out_ch.ready;
  assign pay_last  = (idx_r + XW'(1)) == XW'(n_r);

  assign ram_waddr = wp_r;
  assign ram_wdata = in_ch.rx_byte;
  assign ram_raddr = wrap_add(rp_r, rd_off);

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    fill_nxt     = fill_r;
    wc_nxt       = wc_r;
    tick_nxt     = tick_r;
    ov_nxt       = ov_r && !out_ch.ready;
    len_hi_nxt   = len_hi_r;
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    type_nxt     = type_r;
    code_nxt     = code_r;
    status_nxt   = status_r;
    o_status_nxt = o_status_r;
    o_type_nxt   = o_type_r;
    o_code_nxt   = o_code_r;
    o_count_nxt  = o_count_r;
    o_value_nxt  = o_value_r;
    o_pos_nxt    = o_pos_r;
    o_last_nxt   = o_last_r;
    in_ch.ready  = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    rd_off       = '0;

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          tick_nxt = in_ch.cmd;
          if (!in_ch.cmd && fill_r < FW'(RING_DEPTH)) begin
            ram_we   = 1'b1;
            wp_nxt   = wrap_add(wp_r, XW'(1));
            fill_nxt = fill_r + FW'(1);
          end
          state_nxt = S_HUNT_RD;
        end
      end
      S_HUNT_RD: begin
        if (fill_r == '0) begin
          wc_nxt    = '0;
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_HUNT_CHK;
        end
      end
      S_HUNT_CHK: begin
        if (ram_rdata != cfg.head_value) begin
          rp_nxt    = wrap_add(rp_r, XW'(1));
          fill_nxt  = fill_r - FW'(1);
          wc_nxt    = '0;
          state_nxt = S_HUNT_RD;
        end else if (fill_r >= FW'(5)) begin
          ram_re    = 1'b1;
          rd_off    = XW'(3);
          state_nxt = S_LEN_HI;
        end else begin
          state_nxt = S_TICK;
        end
      end
      S_LEN_HI: begin
        len_hi_nxt = ram_rdata;
        ram_re     = 1'b1;
        rd_off     = XW'(4);
        state_nxt  = S_LEN_LO;
      end
      S_LEN_LO: begin
        if (len_hi_r != '0 || ram_rdata > BYTE_W'(MAX_PAYLOAD)) begin
          rp_nxt    = wrap_add(rp_r, XW'(1));
          fill_nxt  = fill_r - FW'(1);
          wc_nxt    = '0;
          state_nxt = S_HUNT_RD;
        end else begin
          n_nxt = NW'(ram_rdata);
          if (CW'(fill_r) >= CW'(lo_total)) begin
            ram_re    = 1'b1;
            rd_off    = lo_total - XW'(1);
            state_nxt = S_END_CHK;
          end else begin
            state_nxt = S_TICK;
          end
        end
      end
      S_TICK: begin
        state_nxt = S_IDLE;
        if (tick_r) begin
          tick_nxt = 1'b0;
          if (wc_r >= cfg.timeout_ticks) begin
            rp_nxt    = wrap_add(rp_r, XW'(1));
            fill_nxt  = fill_r - FW'(1);
            wc_nxt    = '0;
            state_nxt = S_HUNT_RD;
          end else begin
            wc_nxt = wc_r + BYTE_W'(1);
          end
        end
      end
      S_END_CHK: begin
        if (ram_rdata != cfg.end_value) begin
          rp_nxt    = wrap_add(rp_r, XW'(1));
          fill_nxt  = fill_r - FW'(1);
          wc_nxt    = '0;
          state_nxt = S_HUNT_RD;
        end else begin
          ram_re    = 1'b1;
          rd_off    = XW'(1);
          idx_nxt   = XW'(1);
          sum_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt = sum_r + ram_rdata;
        if (idx_r == XW'(1)) begin
          type_nxt = ram_rdata;
        end
        if (idx_r == XW'(2)) begin
          code_nxt = ram_rdata;
        end
        ram_re = 1'b1;
        if (idx_r == XW'(n_r) + XW'(4)) begin
          rd_off    = XW'(n_r) + XW'(5);
          state_nxt = S_CSUM;
        end else begin
          idx_nxt = idx_r + XW'(1);
          rd_off  = idx_r + XW'(1);
        end
      end
      S_CSUM: begin
        if (n_r == '0) begin
          status_nxt = ST_TOO_SHORT;
        end else if (sum_r != ram_rdata) begin
          status_nxt = ST_CSUM_ERR;
        end else if (type_r == TYPE_ANSWER) begin
          status_nxt = ST_ANSWER_OK;
        end else if (type_r == TYPE_INFORM) begin
          status_nxt = ST_INFORM_OK;
        end else begin
          status_nxt = ST_UNKNOWN_TYPE;
        end
        if (status_nxt == ST_ANSWER_OK || status_nxt == ST_INFORM_OK) begin
          ram_re    = 1'b1;
          rd_off    = XW'(5);
          idx_nxt   = '0;
          state_nxt = S_PAYLOAD;
        end else begin
          state_nxt = S_FAIL;
        end
      end
      S_PAYLOAD: begin
        if (slot_free) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_type_nxt   = type_r;
          o_code_nxt   = code_r;
          o_count_nxt  = COUNT_W'(n_r);
          o_value_nxt  = ram_rdata;
          o_pos_nxt    = COUNT_W'(idx_r);
          o_last_nxt   = pay_last;
          if (pay_last) begin
            state_nxt = S_CONSUME;
          end else begin
            ram_re  = 1'b1;
            rd_off  = idx_r + XW'(6);
            idx_nxt = idx_r + XW'(1);
          end
        end
      end
      S_FAIL: begin
        if (slot_free) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_type_nxt   = type_r;
          o_code_nxt   = code_r;
          o_count_nxt  = COUNT_W'(n_r);
          o_value_nxt  = '0;
          o_pos_nxt    = '0;
          o_last_nxt   = 1'b1;
          state_nxt    = S_CONSUME;
        end
      end
      S_CONSUME: begin
        rp_nxt    = wrap_add(rp_r, n_total);
        fill_nxt  = fill_r - FW'(n_total);
        wc_nxt    = '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      fill_r  <= '0;
      wc_r    <= '0;
      tick_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      fill_r  <= fill_nxt;
      wc_r    <= wc_nxt;
      tick_r  <= tick_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_hi_r   <= len_hi_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    type_r     <= type_nxt;
    code_r     <= code_nxt;
    status_r   <= status_nxt;
    o_status_r <= o_status_nxt;
    o_type_r   <= o_type_nxt;
    o_code_r   <= o_code_nxt;
    o_count_r  <= o_count_nxt;
    o_value_r  <= o_value_nxt;
    o_pos_r    <= o_pos_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.status           = o_status_r;
  assign out_ch.frame_type       = o_type_r;
  assign out_ch.command_code     = o_code_r;
  assign out_ch.payload_count    = o_count_r;
  assign out_ch.payload_value    = o_value_r;
  assign out_ch.payload_position = o_pos_r;
  assign out_ch.last             = o_last_r;

endmodule

@@ rtl/uart_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// uart_frame_deframer: length-prefixed serial frame parser, 8-bit sum check
// Ring buffer of received bytes, head hunt, length/end/sum checks, results.
// ----------------------------------------------------------------------------
// Each input item is a received byte or a time tick. Bytes go into a ring
// memory with one read port, so every look at a held byte is a separate
// registered read. After each item the sequencer hunts for the head
// (reading and dropping bytes that do not match), reads both length bytes,
// reads the end byte, walks the sum over n + 4 bytes, reads the checksum
// and then emits one result per payload byte, or a single result when the
// frame fails its checks; the result side may stall any of these results.
// A new item is taken only once the previous one has finished; its last
// result may still sit in the output register. There is no clearing pass
// after reset.
module uart_frame_deframer import ufd_pkg::*; #(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ufd_in_if.sink               in_ch,
  ufd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(RING_DEPTH);

  cfg_t              cfg_r;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_value    <= HEAD_RESET;
      cfg_r.end_value     <= END_RESET;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAD:    cfg_r.head_value    <= cfg_wdata;
        CFG_END:     cfg_r.end_value     <= cfg_wdata;
        CFG_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ufd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ufd_ctrl #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  a_write_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (in_ch.valid && in_ch.ready && !in_ch.cmd))
    else $error("ring written without an accepted byte");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("ring read and written in the same cycle");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status >= ST_TOO_SHORT) |->
      (out_ch.last && out_ch.payload_value == '0 && out_ch.payload_position == '0))
    else $error("failed frame result not a single zeroed item");

  a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last && out_ch.status <= ST_INFORM_OK) |->
      (COUNT_W'(out_ch.payload_position + COUNT_W'(1)) == out_ch.payload_count))
    else $error("last payload item at wrong position");

endmodule
